// File: sv/wcfr_pkg.sv
// Shared types and constants of the weighted checksum frame receiver.
// Used by every module of the block except wcfr_ram; depends on nothing else.
package wcfr_pkg;

	localparam int MAX_PAYLOAD = 31;
	localparam int LEN_W = 5;
	localparam int SUM_W = 16;
	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 5'd31;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_GAP = 1'b1;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_LENERR = 2'd1,
		ST_SUMERR = 2'd2,
		ST_GAPERR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_PAYLOAD,
		PH_SUM_HI,
		PH_SUM_LO,
		PH_DISCARD
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_DATA
	} back_state_t;

	typedef struct packed {
		logic func;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		status_t status;
		logic [7:0] data_byte;
		logic [LEN_W-1:0] byte_index;
		logic [LEN_W-1:0] frame_len;
		logic has_data;
		logic last;
	} result_t;

	// Work handed from the front to the back: either one status result or
	// the release of a verified, buffered payload.
	typedef struct packed {
		logic release_frame;
		status_t status;
		logic [LEN_W-1:0] frame_len;
	} cmd_t;

	// Payload store write port driven by the front.
	typedef struct packed {
		logic en;
		logic [LEN_W-1:0] addr;
		logic [7:0] data;
	} store_wr_t;

endpackage

// File: sv/weighted_checksum_frame_receiver_top.sv
// Top level of the weighted checksum frame receiver.
// Depends on wcfr_pkg, wcfr_front, wcfr_cmdq, wcfr_back and wcfr_ram.
//
// Frames arrive as a length byte, that many payload bytes and a 16-bit
// checksum (high byte first) equal to the sum of every byte times its
// 1-based position, length byte at position one. The front takes one input
// item per clock cycle while full is low and passes each verdict through a
// short command queue to the back. Errors and empty frames come out as a
// single status result in the output register; a verified frame comes out
// as a burst of payload results, each byte read through the payload store's
// registered read port and then loaded into the output register. The front
// holds off (full high) while the command queue is full, and on the first
// payload byte of a new frame until the previous frame's burst has been
// read out of the store. Configuration writes are always taken.
module weighted_checksum_frame_receiver_top #(
	parameter int CMDQ_DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input wcfr_pkg::in_item_t item,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wcfr_pkg::LEN_W-1:0] cfg_data,
	output logic empty,
	input logic pop,
	output wcfr_pkg::result_t result
);

	logic cmdq_full;
	logic cmdq_empty;
	logic cmd_push;
	logic cmd_pop;
	wcfr_pkg::cmd_t cmd;
	wcfr_pkg::cmd_t head;
	wcfr_pkg::store_wr_t store_wr;
	logic release_done;
	logic ram_ren;
	logic [wcfr_pkg::LEN_W-1:0] ram_raddr;
	logic [7:0] ram_rdata;

	wcfr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.cmdq_full(cmdq_full),
		.cmd_push(cmd_push),
		.cmd(cmd),
		.store_wr(store_wr),
		.release_done(release_done)
	);

	wcfr_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_cmd(cmd),
		.full(cmdq_full),
		.rd_en(cmd_pop),
		.head(head),
		.empty(cmdq_empty)
	);

	wcfr_ram #(
		.WIDTH(8),
		.DEPTH(wcfr_pkg::MAX_PAYLOAD)
	) u_store (
		.clk(clk),
		.wen(store_wr.en),
		.waddr(store_wr.addr),
		.wdata(store_wr.data),
		.ren(ram_ren),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	wcfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.cmdq_empty(cmdq_empty),
		.cmd_pop(cmd_pop),
		.ram_ren(ram_ren),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata),
		.release_done(release_done),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

endmodule

// File: sv/wcfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; no package needed.
module wcfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic wen,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic ren,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wen) begin
			mem_q[waddr] <= wdata;
		end
		if (ren) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/wcfr_cmdq.sv
// Short first-word-fall-through queue of commands between front and back.
// Depends on wcfr_pkg for the command type.
module wcfr_cmdq #(
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input wcfr_pkg::cmd_t wr_cmd,
	output logic full,
	input logic rd_en,
	output wcfr_pkg::cmd_t head,
	output logic empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	wcfr_pkg::cmd_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/wcfr_front.sv
// Front of the receiver: frame state machine, checksum, payload buffering.
// Depends on wcfr_pkg; feeds the command queue and the payload store.
module wcfr_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	input wcfr_pkg::in_item_t item,
	output logic full,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wcfr_pkg::LEN_W-1:0] cfg_data,
	input logic cmdq_full,
	output logic cmd_push,
	output wcfr_pkg::cmd_t cmd,
	output wcfr_pkg::store_wr_t store_wr,
	input logic release_done
);

	wcfr_pkg::phase_t phase_q;
	wcfr_pkg::phase_t phase_d;
	logic [wcfr_pkg::LEN_W-1:0] max_len_q;
	logic [wcfr_pkg::LEN_W-1:0] exp_len_q;
	logic [wcfr_pkg::LEN_W-1:0] count_q;
	logic [wcfr_pkg::SUM_W-1:0] sum_q;
	logic busy_q;

	logic accept;
	logic is_gap;
	logic [7:0] b;
	logic len_bad;
	logic [5:0] weight;
	logic [13:0] prod;
	logic [wcfr_pkg::SUM_W-1:0] sum_next;
	logic [wcfr_pkg::LEN_W:0] count_next;
	logic payload_done;
	logic hi_ok;
	logic lo_ok;
	logic release_set;

	assign cfg_ready = 1'b1;

	// A new payload byte would overwrite the store, so the front waits while
	// the previous frame is still being released.
	assign full = cmdq_full || (phase_q == wcfr_pkg::PH_PAYLOAD && busy_q);
	assign accept = push && !full;
	assign is_gap = (item.func == wcfr_pkg::FUNC_GAP);
	assign b = item.rx_byte;

	assign len_bad = (b > 8'(wcfr_pkg::MAX_PAYLOAD)) || (b > {3'b000, max_len_q});
	assign weight = {1'b0, count_q} + 6'd2;
	assign prod = {8'd0, weight} * {6'd0, b};
	assign sum_next = sum_q + {2'b00, prod};
	assign count_next = {1'b0, count_q} + 6'd1;
	assign payload_done = (count_next >= {1'b0, exp_len_q});
	assign hi_ok = (b == sum_q[15:8]);
	assign lo_ok = (b == sum_q[7:0]);

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			if (is_gap) begin
				phase_d = wcfr_pkg::PH_LEN;
			end else begin
				unique case (phase_q)
					wcfr_pkg::PH_LEN: begin
						if (!len_bad) begin
							phase_d = (b == 8'd0) ? wcfr_pkg::PH_SUM_HI : wcfr_pkg::PH_PAYLOAD;
						end
					end
					wcfr_pkg::PH_PAYLOAD: begin
						if (payload_done) begin
							phase_d = wcfr_pkg::PH_SUM_HI;
						end
					end
					wcfr_pkg::PH_SUM_HI: begin
						phase_d = hi_ok ? wcfr_pkg::PH_SUM_LO : wcfr_pkg::PH_LEN;
					end
					wcfr_pkg::PH_SUM_LO: begin
						phase_d = lo_ok ? wcfr_pkg::PH_DISCARD : wcfr_pkg::PH_LEN;
					end
					wcfr_pkg::PH_DISCARD: begin
						phase_d = wcfr_pkg::PH_DISCARD;
					end
					default: begin
						phase_d = wcfr_pkg::PH_LEN;
					end
				endcase
			end
		end
	end

	always_comb begin
		cmd_push = 1'b0;
		cmd.release_frame = 1'b0;
		cmd.status = wcfr_pkg::ST_OK;
		cmd.frame_len = exp_len_q;
		store_wr.en = 1'b0;
		store_wr.addr = count_q;
		store_wr.data = b;
		release_set = 1'b0;
		if (accept) begin
			if (is_gap) begin
				if (phase_q == wcfr_pkg::PH_PAYLOAD || phase_q == wcfr_pkg::PH_SUM_HI ||
					phase_q == wcfr_pkg::PH_SUM_LO) begin
					cmd_push = 1'b1;
					cmd.status = wcfr_pkg::ST_GAPERR;
				end
			end else begin
				unique case (phase_q)
					wcfr_pkg::PH_LEN: begin
						if (len_bad) begin
							cmd_push = 1'b1;
							cmd.status = wcfr_pkg::ST_LENERR;
							cmd.frame_len = '0;
						end
					end
					wcfr_pkg::PH_PAYLOAD: begin
						store_wr.en = 1'b1;
					end
					wcfr_pkg::PH_SUM_HI: begin
						if (!hi_ok) begin
							cmd_push = 1'b1;
							cmd.status = wcfr_pkg::ST_SUMERR;
						end
					end
					wcfr_pkg::PH_SUM_LO: begin
						cmd_push = 1'b1;
						if (!lo_ok) begin
							cmd.status = wcfr_pkg::ST_SUMERR;
						end else if (exp_len_q != '0) begin
							cmd.release_frame = 1'b1;
							release_set = 1'b1;
						end
					end
					wcfr_pkg::PH_DISCARD: begin
						cmd_push = 1'b0;
					end
					default: begin
						cmd_push = 1'b0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wcfr_pkg::PH_LEN;
			max_len_q <= wcfr_pkg::MAX_LEN_RESET;
			exp_len_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			busy_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			busy_q <= (busy_q && !release_done) || release_set;
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			if (accept && !is_gap) begin
				if (phase_q == wcfr_pkg::PH_LEN && !len_bad) begin
					exp_len_q <= b[wcfr_pkg::LEN_W-1:0];
					count_q <= '0;
					sum_q <= {8'd0, b};
				end else if (phase_q == wcfr_pkg::PH_PAYLOAD) begin
					count_q <= count_next[wcfr_pkg::LEN_W-1:0];
					sum_q <= sum_next;
				end
			end
		end
	end

endmodule

// File: sv/wcfr_back.sv
// Back of the receiver: turns commands into results, reading released
// payload from the store. Depends on wcfr_pkg.
module wcfr_back (
	input logic clk,
	input logic arst_n,
	input wcfr_pkg::cmd_t head,
	input logic cmdq_empty,
	output logic cmd_pop,
	output logic ram_ren,
	output logic [wcfr_pkg::LEN_W-1:0] ram_raddr,
	input logic [7:0] ram_rdata,
	output logic release_done,
	output wcfr_pkg::result_t result,
	output logic empty,
	input logic pop
);

	wcfr_pkg::back_state_t state_q;
	wcfr_pkg::back_state_t state_d;
	logic [wcfr_pkg::LEN_W-1:0] idx_q;
	logic [wcfr_pkg::LEN_W-1:0] len_q;
	logic out_valid_q;
	wcfr_pkg::result_t out_q;

	logic out_free;
	logic last_byte;
	logic load_out;
	logic start_release;
	wcfr_pkg::result_t out_d;

	// The output register frees up in the same cycle its item is taken.
	assign out_free = !out_valid_q || pop;
	assign last_byte = (idx_q == len_q - 1'b1);
	assign empty = !out_valid_q;
	assign result = out_q;
	assign ram_raddr = idx_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wcfr_pkg::BK_IDLE: begin
				if (!cmdq_empty && head.release_frame) begin
					state_d = wcfr_pkg::BK_READ;
				end
			end
			wcfr_pkg::BK_READ: begin
				state_d = wcfr_pkg::BK_DATA;
			end
			wcfr_pkg::BK_DATA: begin
				if (out_free) begin
					state_d = last_byte ? wcfr_pkg::BK_IDLE : wcfr_pkg::BK_READ;
				end
			end
			default: begin
				state_d = wcfr_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop = 1'b0;
		ram_ren = 1'b0;
		load_out = 1'b0;
		start_release = 1'b0;
		release_done = 1'b0;
		out_d.status = wcfr_pkg::ST_OK;
		out_d.data_byte = ram_rdata;
		out_d.byte_index = idx_q;
		out_d.frame_len = len_q;
		out_d.has_data = 1'b1;
		out_d.last = last_byte;
		unique case (state_q)
			wcfr_pkg::BK_IDLE: begin
				if (!cmdq_empty) begin
					if (head.release_frame) begin
						cmd_pop = 1'b1;
						start_release = 1'b1;
					end else if (out_free) begin
						cmd_pop = 1'b1;
						load_out = 1'b1;
						out_d.status = head.status;
						out_d.data_byte = '0;
						out_d.byte_index = '0;
						out_d.frame_len = head.frame_len;
						out_d.has_data = 1'b0;
						out_d.last = 1'b1;
					end
				end
			end
			wcfr_pkg::BK_READ: begin
				ram_ren = 1'b1;
			end
			wcfr_pkg::BK_DATA: begin
				if (out_free) begin
					load_out = 1'b1;
					release_done = last_byte;
				end
			end
			default: begin
				cmd_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wcfr_pkg::BK_IDLE;
			idx_q <= '0;
			len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_release) begin
				idx_q <= '0;
				len_q <= head.frame_len;
			end else if (state_q == wcfr_pkg::BK_DATA && out_free && !last_byte) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
